// ===== rtl/oau_pkg.sv =====
// oau_pkg: request and result types and command codes of the 6502 operand
// addressing unit; no dependencies
package oau_pkg;

  typedef struct packed {
    logic [4:0] command;
    logic [7:0] operand_low;
    logic [7:0] operand_high;
    logic [7:0] index_x;
    logic [7:0] index_y;
    logic [7:0] store_data;
  } request_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] effective_address;
    logic        page_crossed;
  } result_t;

  localparam int unsigned MEM_DEPTH = 65536;
  localparam int unsigned MEM_WIDTH = 8;

  localparam logic [4:0] CMD_IMM      = 5'd0;
  localparam logic [4:0] CMD_REL      = 5'd1;
  localparam logic [4:0] CMD_ZP       = 5'd2;
  localparam logic [4:0] CMD_ZPX      = 5'd3;
  localparam logic [4:0] CMD_ZPY      = 5'd4;
  localparam logic [4:0] CMD_ABS      = 5'd5;
  localparam logic [4:0] CMD_ABSX     = 5'd6;
  localparam logic [4:0] CMD_ABSY     = 5'd7;
  localparam logic [4:0] CMD_INDX     = 5'd8;
  localparam logic [4:0] CMD_INDY     = 5'd9;
  localparam logic [4:0] CMD_ABSX_NP  = 5'd10;
  localparam logic [4:0] CMD_WR_ZP    = 5'd11;
  localparam logic [4:0] CMD_WR_INDY  = 5'd18;

  // write commands map onto the read modes zp..indy
  localparam logic [4:0] WRITE_OFFSET = 5'd9;

endpackage

// ===== rtl/cpu6502_operand_addressing_unit_top.sv =====
// from accepted request to done: immediate, relative, unused commands and direct writes
// finish from idle, direct reads go via the data state, indirect writes via ptr1 and ptr2,
// indirect reads via ptr1, ptr2 and data; one request at a time, all accesses share
// the single ram port; reset starts a clearing pass that zeroes all 65536 memory words,
// busy high throughout; results are strobed by done for one cycle and cannot be stalled
module cpu6502_operand_addressing_unit_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  oau_pkg::request_t request,
  output logic             done,
  output oau_pkg::result_t  result
);
  import oau_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PTR1  = 3'd2;
  localparam logic [2:0] S_PTR2  = 3'd3;
  localparam logic [2:0] S_DATA  = 3'd4;

  localparam logic [1:0] K_NONE   = 2'd0;
  localparam logic [1:0] K_IMM    = 2'd1;
  localparam logic [1:0] K_DIRECT = 2'd2;
  localparam logic [1:0] K_IND    = 2'd3;

  logic [2:0]  state;
  logic [15:0] clr_addr;
  logic [7:0]  ptr_zp;
  logic [7:0]  ptr_lo;
  logic        is_write;
  logic        use_y;
  logic [7:0]  idx_y;
  logic [7:0]  store;
  logic [15:0] ea;
  logic        pc;

  logic        accept;
  logic        req_write;
  logic [4:0]  mode;
  logic [1:0]  kind;
  logic        penalty;
  logic [15:0] abs_base;
  logic [15:0] d_ea;
  logic [7:0]  zp_ptr;
  logic [15:0] i_base;
  logic [15:0] i_ea;

  logic        ram_we;
  logic [15:0] ram_addr;
  logic [7:0]  ram_wdata;
  logic [7:0]  ram_rdata;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // command decode
  always_comb begin
    req_write = (request.command >= CMD_WR_ZP) && (request.command <= CMD_WR_INDY);
    mode      = req_write ? (request.command - WRITE_OFFSET) : request.command;
    abs_base  = {request.operand_high, request.operand_low};
    kind      = K_NONE;
    penalty   = 1'b0;
    d_ea      = '0;
    zp_ptr    = request.operand_low;
    unique case (mode)
      CMD_IMM, CMD_REL: begin
        kind = K_IMM;
      end
      CMD_ZP: begin
        kind = K_DIRECT;
        d_ea = {8'h00, request.operand_low};
      end
      CMD_ZPX: begin
        kind = K_DIRECT;
        d_ea = {8'h00, request.operand_low + request.index_x};
      end
      CMD_ZPY: begin
        kind = K_DIRECT;
        d_ea = {8'h00, request.operand_low + request.index_y};
      end
      CMD_ABS: begin
        kind = K_DIRECT;
        d_ea = abs_base;
      end
      CMD_ABSX: begin
        kind    = K_DIRECT;
        d_ea    = abs_base + {8'h00, request.index_x};
        penalty = 1'b1;
      end
      CMD_ABSY: begin
        kind    = K_DIRECT;
        d_ea    = abs_base + {8'h00, request.index_y};
        penalty = 1'b1;
      end
      CMD_ABSX_NP: begin
        kind = K_DIRECT;
        d_ea = abs_base + {8'h00, request.index_x};
      end
      CMD_INDX: begin
        kind   = K_IND;
        zp_ptr = request.operand_low + request.index_x;
      end
      CMD_INDY: begin
        kind = K_IND;
      end
      default: begin
        kind = K_NONE;
      end
    endcase
  end

  // pointer high byte arrives in ptr2
  assign i_base = {ram_rdata, ptr_lo};
  assign i_ea   = i_base + (use_y ? {8'h00, idx_y} : 16'h0000);

  // ram port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = ea;
    ram_wdata = store;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
      end
      S_IDLE: begin
        ram_addr  = (kind == K_IND) ? {8'h00, zp_ptr} : d_ea;
        ram_we    = accept && req_write && (kind == K_DIRECT);
        ram_wdata = request.store_data;
      end
      S_PTR1: begin
        ram_addr = {8'h00, ptr_zp + 8'd1};
      end
      S_PTR2: begin
        ram_addr = i_ea;
        ram_we   = is_write;
      end
      default: begin
        ram_addr = ea;
      end
    endcase
  end

  oau_ram #(
    .WIDTH(MEM_WIDTH),
    .DEPTH(MEM_DEPTH)
  ) u_mem (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 16'd1;
          if (clr_addr == 16'hFFFF) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            is_write <= req_write;
            use_y    <= (mode == CMD_INDY);
            idx_y    <= request.index_y;
            store    <= request.store_data;
            ptr_zp   <= zp_ptr;
            case (kind)
              K_IMM: begin
                result <= '{read_data: request.operand_low,
                            effective_address: 16'h0000, page_crossed: 1'b0};
                done   <= 1'b1;
              end
              K_DIRECT: begin
                if (req_write) begin
                  result <= '{read_data: 8'h00, effective_address: d_ea,
                              page_crossed: 1'b0};
                  done   <= 1'b1;
                end else begin
                  ea    <= d_ea;
                  pc    <= penalty && (d_ea[15:8] != request.operand_high);
                  state <= S_DATA;
                end
              end
              K_IND: begin
                state <= S_PTR1;
              end
              default: begin
                result <= '0;
                done   <= 1'b1;
              end
            endcase
          end
        end
        S_PTR1: begin
          ptr_lo <= ram_rdata;
          state  <= S_PTR2;
        end
        S_PTR2: begin
          ea <= i_ea;
          pc <= use_y && (i_ea[15:8] != ram_rdata);
          if (is_write) begin
            result <= '{read_data: 8'h00, effective_address: i_ea, page_crossed: 1'b0};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_DATA;
          end
        end
        S_DATA: begin
          result <= '{read_data: ram_rdata, effective_address: ea, page_crossed: pc};
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/oau_ram.sv =====
// oau_ram: generic single-port synchronous ram with registered read
// no dependencies
module oau_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/oau_checker.sv =====
// oau_checker: port-level assertions for the 6502 operand addressing unit
// depends on oau_pkg; bound to cpu6502_operand_addressing_unit_top
module oau_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input oau_pkg::request_t request,
  input logic             done,
  input oau_pkg::result_t  result
);
  import oau_pkg::*;

  // reset always enters the clearing pass
  a_reset_clears: assert property (@(posedge clk)
    rst |=> busy && !done)
    else $error("reset did not start clearing pass");

  // a result only appears with the unit ready again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // every accepted request either keeps the unit busy or completes at once
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request lost");

  // immediate and relative requests echo operand_low in the next cycle
  a_imm_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.command == CMD_IMM || request.command == CMD_REL))
    |=> done && result.read_data == $past(request.operand_low)
        && result.effective_address == 16'h0000 && !result.page_crossed)
    else $error("immediate result wrong");

  // zero-page write reports its address and no data
  a_wr_zp_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.command == CMD_WR_ZP)
    |=> done && result.read_data == 8'h00
        && result.effective_address == {8'h00, $past(request.operand_low)})
    else $error("zero-page write result wrong");

endmodule

bind cpu6502_operand_addressing_unit_top oau_checker u_oau_checker (.*);

// ===== sim/oau_checker.sv =====
// oau_scoreboard: watches the request and result channels of the operand addressing
// unit, predicts each result from its own image of the 64 KiB memory and compares
// depends on oau_pkg for the request and result types and the command codes
`timescale 1ns / 100ps

module oau_scoreboard (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  oau_pkg::request_t request,
  input  logic              done,
  input  oau_pkg::result_t  result,
  output int                fail_count,
  output int                pending,
  output int                checked,
  output int                crossings
);
  import oau_pkg::*;

  logic [7:0] ram_image [0:MEM_DEPTH-1];
  result_t    expected_operands[$];
  int         errs;
  int         compared;
  int         crossed;

  function automatic result_t resolve_operand(input request_t req);
    result_t     res;
    logic [4:0]  mode;
    logic [15:0] base;
    logic [15:0] ea;
    logic [7:0]  zp;
    logic [7:0]  zp_next;
    logic        penalty;
    logic        store;
    logic        valid;
    res = '0;
    base = '0;
    ea = '0;
    penalty = 1'b0;
    store = 1'b0;
    valid = 1'b1;
    mode = req.command;
    if (req.command == CMD_IMM || req.command == CMD_REL) begin
      res.read_data = req.operand_low;
      return res;
    end
    if (req.command >= CMD_WR_ZP && req.command <= CMD_WR_INDY) begin
      store = 1'b1;
      mode = req.command - WRITE_OFFSET;
    end
    case (mode)
      CMD_ZP: ea = {8'h00, req.operand_low};
      CMD_ZPX: begin
        zp = req.operand_low + req.index_x;
        ea = {8'h00, zp};
      end
      CMD_ZPY: begin
        zp = req.operand_low + req.index_y;
        ea = {8'h00, zp};
      end
      CMD_ABS: ea = {req.operand_high, req.operand_low};
      CMD_ABSX: begin
        base = {req.operand_high, req.operand_low};
        ea = base + {8'h00, req.index_x};
        penalty = 1'b1;
      end
      CMD_ABSY: begin
        base = {req.operand_high, req.operand_low};
        ea = base + {8'h00, req.index_y};
        penalty = 1'b1;
      end
      CMD_INDX: begin
        zp = req.operand_low + req.index_x;
        zp_next = zp + 8'd1;
        ea = {ram_image[{8'h00, zp_next}], ram_image[{8'h00, zp}]};
      end
      CMD_INDY: begin
        zp = req.operand_low;
        zp_next = zp + 8'd1;
        base = {ram_image[{8'h00, zp_next}], ram_image[{8'h00, zp}]};
        ea = base + {8'h00, req.index_y};
        penalty = 1'b1;
      end
      CMD_ABSX_NP: ea = {req.operand_high, req.operand_low} + {8'h00, req.index_x};
      default: valid = 1'b0;
    endcase
    if (!valid) begin
      return '0;
    end
    if (store) begin
      ram_image[ea] = req.store_data;
    end else begin
      res.read_data = ram_image[ea];
      res.page_crossed = penalty && (base[15:8] != ea[15:8]);
    end
    res.effective_address = ea;
    return res;
  endfunction

  always @(posedge clk) begin
    result_t exp_res;
    if (rst) begin
      for (int i = 0; i < MEM_DEPTH; i++) begin
        ram_image[i] = '0;
      end
      expected_operands.delete();
      errs = 0;
      compared = 0;
      crossed = 0;
    end else begin
      if (done === 1'b1) begin
        if (expected_operands.size() == 0) begin
          errs++;
          $display("%0t: result rd=%h ea=%h pc=%b with no request outstanding",
                   $time, result.read_data, result.effective_address,
                   result.page_crossed);
        end else begin
          exp_res = expected_operands.pop_front();
          compared++;
          if (exp_res.page_crossed) begin
            crossed++;
          end
          if (result !== exp_res) begin
            errs++;
            $display("%0t: expected rd=%h ea=%h pc=%b actual rd=%h ea=%h pc=%b",
                     $time, exp_res.read_data, exp_res.effective_address,
                     exp_res.page_crossed, result.read_data,
                     result.effective_address, result.page_crossed);
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        expected_operands.push_back(resolve_operand(request));
      end
    end
    fail_count <= errs;
    pending <= expected_operands.size();
    checked <= compared;
    crossings <= crossed;
  end

endmodule

// ===== sim/tb_cpu6502_operand_addressing_unit_top.sv =====
// tb_cpu6502_operand_addressing_unit_top: drives directed and random addressing
// requests into the operand addressing unit and reports the verdict
// depends on oau_pkg, oau_scoreboard and cpu6502_operand_addressing_unit_top
`timescale 1ns / 100ps

module tb_cpu6502_operand_addressing_unit_top;
  import oau_pkg::*;

  localparam int         DIRECTED_REQUESTS = 25;
  localparam int         RANDOM_REQUESTS   = 1000;
  localparam int         STALL_LIMIT       = 200000;
  localparam logic [4:0] CMD_UNUSED_LO     = CMD_WR_INDY + 5'd1;
  localparam logic [4:0] CMD_UNUSED_HI     = 5'h1F;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     done;
  result_t  result;

  int fail_count;
  int pending;
  int checked;
  int crossings;
  int sent_requests = 0;
  int stall_cycles = 0;
  bit quiet = 1'b0;

  cpu6502_operand_addressing_unit_top dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  oau_scoreboard scoreboard (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .crossings  (crossings)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic request_t make_req(input logic [4:0] cmd, input logic [7:0] lo,
                                        input logic [7:0] hi, input logic [7:0] x,
                                        input logic [7:0] y, input logic [7:0] sd);
    request_t req;
    req.command = cmd;
    req.operand_low = lo;
    req.operand_high = hi;
    req.index_x = x;
    req.index_y = y;
    req.store_data = sd;
    return req;
  endfunction

  function automatic logic [15:0] pick_address();
    logic [15:0] addr;
    addr = 16'($urandom);
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        case ($urandom_range(0, 3))
          0: addr[15:8] = 8'h00;
          1: addr[15:8] = 8'h01;
          2: addr[15:8] = 8'hFF;
          default: addr[15:8] = 8'($urandom_range(0, 3));
        endcase
      end
      2: addr[7:0] = 8'($urandom_range(0, 1) ? $urandom_range(8'hF8, 8'hFF)
                                               : $urandom_range(0, 7));
      default: addr[15:8] = 8'h00;
    endcase
    return addr;
  endfunction

  // direct (non-pointer) request whose effective address is addr
  function automatic request_t address_request(input bit store, input logic [15:0] addr,
                                               input logic [7:0] sd);
    request_t   req;
    logic [4:0] mode;
    int         pick;
    req = make_req(CMD_IMM, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), sd);
    pick = (addr[15:8] == 8'h00) ? $urandom_range(0, 6) : $urandom_range(3, 6);
    case (pick)
      0: begin
        mode = CMD_ZP;
        req.operand_low = addr[7:0];
      end
      1: begin
        mode = CMD_ZPX;
        req.operand_low = addr[7:0] - req.index_x;
      end
      2: begin
        mode = CMD_ZPY;
        req.operand_low = addr[7:0] - req.index_y;
      end
      3: begin
        mode = CMD_ABS;
        {req.operand_high, req.operand_low} = addr;
      end
      4: begin
        mode = CMD_ABSX;
        {req.operand_high, req.operand_low} = addr - {8'h00, req.index_x};
      end
      5: begin
        mode = CMD_ABSY;
        {req.operand_high, req.operand_low} = addr - {8'h00, req.index_y};
      end
      default: begin
        mode = store ? CMD_ABSX : CMD_ABSX_NP;
        {req.operand_high, req.operand_low} = addr - {8'h00, req.index_x};
      end
    endcase
    req.command = store ? mode + WRITE_OFFSET : mode;
    return req;
  endfunction

  task automatic send_request(input request_t req);
    logic [63:0] noise;
    int          gap;
    if (!quiet && $urandom_range(0, 99) < 6) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) begin
        noise = {$urandom, $urandom};
        request <= noise[$bits(request_t)-1:0];
        @(posedge clk);
      end
    end
    start <= 1'b1;
    request <= req;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sent_requests++;
  endtask

  task automatic send_noise();
    request_t req;
    req = make_req(5'($urandom_range(0, 1) ? $urandom_range(0, 18) : $urandom_range(0, 31)),
                   8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    send_request(req);
  endtask

  task automatic store_then_load();
    logic [15:0] addr;
    addr = pick_address();
    send_request(address_request(1'b1, addr, 8'($urandom)));
    send_request(address_request(1'b0, addr, 8'($urandom)));
    if ($urandom_range(0, 1)) begin
      send_request(address_request(1'b0, addr + 16'd1, 8'($urandom)));
    end
  endtask

  task automatic pointer_sequence();
    logic [15:0] addr;
    logic [15:0] ptr;
    logic [7:0]  zp;
    logic [7:0]  x;
    logic [7:0]  y;
    bit          via_y;
    addr = pick_address();
    zp = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom);
    x = 8'($urandom);
    y = 8'($urandom);
    via_y = 1'($urandom_range(0, 1));
    ptr = via_y ? addr - {8'h00, y} : addr;
    send_request(make_req(CMD_WR_ZP, zp, 8'($urandom), 8'($urandom), 8'($urandom),
                          ptr[7:0]));
    send_request(make_req(CMD_WR_ZP, zp + 8'd1, 8'($urandom), 8'($urandom), 8'($urandom),
                          ptr[15:8]));
    if ($urandom_range(0, 1)) begin
      if (via_y) begin
        send_request(make_req(CMD_WR_INDY, zp, 8'($urandom), x, y, 8'($urandom)));
      end else begin
        send_request(make_req(CMD_INDX + WRITE_OFFSET, zp - x, 8'($urandom), x, y,
                              8'($urandom)));
      end
    end else begin
      send_request(address_request(1'b1, addr, 8'($urandom)));
    end
    if (via_y) begin
      send_request(make_req(CMD_INDY, zp, 8'($urandom), x, y, 8'($urandom)));
    end else begin
      send_request(make_req(CMD_INDX, zp - x, 8'($urandom), x, y, 8'($urandom)));
    end
    if ($urandom_range(0, 1)) begin
      send_request(address_request(1'b0, addr, 8'($urandom)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // pointer at ff wraps to 00 for its high byte
    send_request(make_req(CMD_WR_ZP, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h34));
    send_request(make_req(CMD_WR_ZP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h12));
    send_request(make_req(CMD_INDX, 8'hF0, 8'h00, 8'h0F, 8'h00, 8'h00));
    send_request(make_req(CMD_INDX + WRITE_OFFSET, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hA5));
    send_request(make_req(CMD_ABS, 8'h34, 8'h12, 8'h00, 8'h00, 8'h00));
    send_request(make_req(CMD_INDY, 8'hFF, 8'h00, 8'h00, 8'hCC, 8'h00));
    send_request(make_req(CMD_WR_INDY, 8'hFF, 8'h00, 8'h00, 8'hCC, 8'h5A));
    send_request(make_req(CMD_ABSY, 8'h34, 8'h12, 8'h00, 8'hCC, 8'h00));
    // 16-bit wrap from page ff to page 00
    send_request(make_req(CMD_ABSX, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h00));
    send_request(make_req(CMD_ABSX_NP, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h00));
    send_request(make_req(CMD_ABSX, 8'h00, 8'h13, 8'h00, 8'h00, 8'h00));
    send_request(make_req(CMD_IMM, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_request(make_req(CMD_REL, 8'h80, 8'h12, 8'h34, 8'h56, 8'h78));
    send_request(make_req(CMD_IMM, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_request(make_req(CMD_ZPX, 8'hF0, 8'hFF, 8'h10, 8'h00, 8'h00));
    send_request(make_req(CMD_ZPY, 8'h01, 8'hFF, 8'h00, 8'hFE, 8'h00));
    send_request(make_req(CMD_ZPX + WRITE_OFFSET, 8'h80, 8'h00, 8'hFF, 8'h00, 8'hFF));
    send_request(make_req(CMD_ZPY + WRITE_OFFSET, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00));
    send_request(make_req(CMD_ABS + WRITE_OFFSET, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h77));
    send_request(make_req(CMD_ABSX + WRITE_OFFSET, 8'hF0, 8'hFF, 8'h20, 8'h00, 8'h66));
    send_request(make_req(CMD_ABSY + WRITE_OFFSET, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h99));
    send_request(make_req(CMD_ABS, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00));
    send_request(make_req(CMD_ZP, 8'h10, 8'hAA, 8'h55, 8'hAA, 8'h55));
    send_request(make_req(CMD_UNUSED_LO, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom)));
    send_request(make_req(CMD_UNUSED_HI, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));

    while (sent_requests < DIRECTED_REQUESTS + RANDOM_REQUESTS) begin
      quiet = (sent_requests >= 400 && sent_requests < 600);
      case ($urandom_range(0, 9))
        0, 1, 2: send_noise();
        3, 4, 5: store_then_load();
        default: pointer_sequence();
      endcase
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d requests driven (%0d directed), %0d results compared",
             sent_requests, DIRECTED_REQUESTS, checked);
    $display("read and write forms of every mode, pointer wrap, %0d page crossings",
             crossings);
    if (pending != 0) begin
      $display("%0d results never arrived", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
